/* rtl/mml_pkg.sv */
// ----------------------------------------------------------------------------
// mml_pkg
// Token kind codes and the recogniser state record of the maximal munch lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package mml_pkg;

	localparam logic [3:0] KIND_START   = 4'd0;
	localparam logic [3:0] KIND_EOF     = 4'd1;
	localparam logic [3:0] KIND_COMMENT = 4'd2;
	localparam logic [3:0] KIND_LPAREN  = 4'd3;
	localparam logic [3:0] KIND_RPAREN  = 4'd4;
	localparam logic [3:0] KIND_INTEGER = 4'd5;
	localparam logic [3:0] KIND_FLOAT   = 4'd6;
	localparam logic [3:0] KIND_STRING  = 4'd7;
	localparam logic [3:0] KIND_CHAR    = 4'd8;
	localparam logic [3:0] KIND_SPACE   = 4'd9;
	localparam logic [3:0] KIND_IDENT   = 4'd10;
	localparam logic [3:0] KIND_KEYWORD = 4'd11;
	localparam logic [3:0] KIND_ERROR   = 4'd12;

	// All recognisers together; all-zero is the start state of every one.
	typedef struct packed {
		logic [2:0] cmt;
		logic [1:0] par;
		logic       par_left;
		logic [2:0] dec;
		logic [2:0] hex;
		logic [2:0] flt;
		logic [2:0] str;
		logic [2:0] chr;
		logic [1:0] spc;
		logic [1:0] idn;
		logic [1:0] kwd;
	} scan_t;

endpackage

`default_nettype wire

/* rtl/maximal_munch_lexer.sv */
// ----------------------------------------------------------------------------
// maximal_munch_lexer
// Longest-match lexer over a byte stream with nine parallel recognisers.
// ----------------------------------------------------------------------------
// One byte request is taken per cycle. It lands in an input register and is
// lexed from there by the recogniser logic, which pushes zero, one or two
// tokens into a four-entry token queue; tokens leave the queue one per cycle
// while out_stall is low. A request in the input register is held, and the
// input stalls, while the queue holds more than two tokens. A request yields
// two tokens for a flushed token plus an error or eof, or for the start token
// plus another. Offsets wrap at 2**OFFSET_BITS and token lengths saturate at
// 2**LENGTH_BITS-1. A token of kind start or eof has length zero; last_of_run
// marks the final token that one input byte or end-of-input request produced.
// ----------------------------------------------------------------------------
`default_nettype none

module maximal_munch_lexer #(
	parameter int OFFSET_BITS = 32,
	parameter int LENGTH_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output      logic                   in_stall,
	input  wire logic [7:0]             in_byte,
	input  wire logic                   end_of_input,
	output      logic                   out_valid,
	input  wire logic                   out_stall,
	output      logic [3:0]             token_kind,
	output      logic [OFFSET_BITS-1:0] token_start,
	output      logic [LENGTH_BITS-1:0] token_length,
	output      logic                   last_of_run
);
	import mml_pkg::*;

	// recogniser state codes
	localparam logic [2:0] CMT_START = 3'd0, CMT_SLASH = 3'd1, CMT_LINE = 3'd2,
		CMT_LINE_END = 3'd3, CMT_BLOCK = 3'd4, CMT_STAR = 3'd5, CMT_CLOSED = 3'd6,
		CMT_DEAD = 3'd7;
	localparam logic [1:0] PAR_START = 2'd0, PAR_LEFT = 2'd1, PAR_RIGHT = 2'd2,
		PAR_DEAD = 2'd3;
	localparam logic [2:0] DEC_START = 3'd0, DEC_MINUS = 3'd1, DEC_ZERO = 3'd2,
		DEC_DIGITS = 3'd3, DEC_DEAD = 3'd4;
	localparam logic [2:0] HEX_START = 3'd0, HEX_ZERO = 3'd1, HEX_X = 3'd2,
		HEX_DIGITS = 3'd3, HEX_DEAD = 3'd4;
	localparam logic [2:0] FLT_START = 3'd0, FLT_MINUS = 3'd1, FLT_INT = 3'd2,
		FLT_DOT = 3'd3, FLT_FRAC = 3'd4, FLT_SUFFIX = 3'd5, FLT_DEAD = 3'd6;
	localparam logic [2:0] STR_START = 3'd0, STR_OPEN = 3'd1, STR_BODY = 3'd2,
		STR_ESC = 3'd3, STR_CLOSED = 3'd4, STR_DEAD = 3'd5;
	localparam logic [2:0] CHR_START = 3'd0, CHR_OPEN = 3'd1, CHR_BODY = 3'd2,
		CHR_ESC = 3'd3, CHR_CLOSED = 3'd4, CHR_DEAD = 3'd5;
	localparam logic [1:0] SPC_START = 2'd0, SPC_RUN = 2'd1, SPC_DEAD = 2'd2;
	localparam logic [1:0] IDN_START = 2'd0, IDN_RUN = 2'd1, IDN_DEAD = 2'd2;
	localparam logic [1:0] KWD_EMPTY = 2'd0, KWD_F = 2'd1, KWD_FN = 2'd2,
		KWD_OTHER = 2'd3;

	localparam int QDEPTH = 4;

	typedef struct packed {
		logic [3:0]             kind;
		logic [OFFSET_BITS-1:0] start;
		logic [LENGTH_BITS-1:0] length;
		logic                   last;
	} token_t;

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == " " || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
	endfunction

	function automatic logic is_paren(input logic [7:0] b);
		return b == "(" || b == ")";
	endfunction

	function automatic scan_t scan_next(input scan_t s, input logic [7:0] b);
		scan_t n;
		n = s;
		unique case (s.cmt)
			CMT_START: n.cmt = (b == "/") ? CMT_SLASH : CMT_DEAD;
			CMT_SLASH: n.cmt = (b == "/") ? CMT_LINE : (b == "*") ? CMT_BLOCK : CMT_DEAD;
			CMT_LINE: if (b == 8'h0a) n.cmt = CMT_LINE_END;
			CMT_BLOCK: if (b == "*") n.cmt = CMT_STAR;
			CMT_STAR: n.cmt = (b == "*") ? CMT_STAR : (b == "/") ? CMT_CLOSED : CMT_BLOCK;
			CMT_LINE_END, CMT_CLOSED: n.cmt = CMT_DEAD;
			default: n.cmt = s.cmt;
		endcase
		unique case (s.par)
			PAR_START: begin
				if (b == "(") begin
					n.par = PAR_LEFT;
					n.par_left = 1'b1;
				end else if (b == ")") begin
					n.par = PAR_RIGHT;
					n.par_left = 1'b0;
				end else begin
					n.par = PAR_DEAD;
				end
			end
			PAR_LEFT, PAR_RIGHT: n.par = PAR_DEAD;
			default: n.par = s.par;
		endcase
		unique case (s.dec)
			DEC_START, DEC_MINUS: begin
				if (s.dec == DEC_START && b == "-") n.dec = DEC_MINUS;
				else if (b == "0") n.dec = DEC_ZERO;
				else if (is_digit(b)) n.dec = DEC_DIGITS;
				else n.dec = DEC_DEAD;
			end
			DEC_ZERO: n.dec = DEC_DEAD;
			DEC_DIGITS: if (!is_digit(b)) n.dec = DEC_DEAD;
			default: n.dec = s.dec;
		endcase
		unique case (s.hex)
			HEX_START: n.hex = (b == "0") ? HEX_ZERO : HEX_DEAD;
			HEX_ZERO: n.hex = (b == "x") ? HEX_X : HEX_DEAD;
			HEX_X: n.hex = is_hex(b) ? HEX_DIGITS : HEX_DEAD;
			HEX_DIGITS: if (!is_hex(b)) n.hex = HEX_DEAD;
			default: n.hex = s.hex;
		endcase
		unique case (s.flt)
			FLT_START, FLT_MINUS, FLT_INT: begin
				if (s.flt == FLT_START && b == "-") n.flt = FLT_MINUS;
				else if (is_digit(b)) n.flt = FLT_INT;
				else if (b == ".") n.flt = FLT_DOT;
				else n.flt = FLT_DEAD;
			end
			FLT_DOT: n.flt = is_digit(b) ? FLT_FRAC : FLT_DEAD;
			FLT_FRAC: begin
				if (is_digit(b)) n.flt = FLT_FRAC;
				else if (b == "f" || b == "d") n.flt = FLT_SUFFIX;
				else n.flt = FLT_DEAD;
			end
			FLT_SUFFIX: n.flt = FLT_DEAD;
			default: n.flt = s.flt;
		endcase
		unique case (s.str)
			STR_START: n.str = (b == 8'h22) ? STR_OPEN : STR_DEAD;
			STR_OPEN, STR_BODY: begin
				if (b == 8'h22) n.str = STR_CLOSED;
				else if (b == 8'h5c) n.str = STR_ESC;
				else n.str = STR_BODY;
			end
			STR_ESC: n.str = STR_BODY;
			STR_CLOSED: n.str = STR_DEAD;
			default: n.str = s.str;
		endcase
		unique case (s.chr)
			CHR_START: n.chr = (b == 8'h27) ? CHR_OPEN : CHR_DEAD;
			CHR_OPEN: n.chr = (b == 8'h5c) ? CHR_ESC : CHR_BODY;
			CHR_BODY: n.chr = (b == 8'h27) ? CHR_CLOSED : CHR_DEAD;
			CHR_ESC: n.chr = CHR_BODY;
			CHR_CLOSED: n.chr = CHR_DEAD;
			default: n.chr = s.chr;
		endcase
		if (s.spc == SPC_START || s.spc == SPC_RUN)
			n.spc = is_space(b) ? SPC_RUN : SPC_DEAD;
		unique case (s.idn)
			IDN_START: n.idn = (is_space(b) || is_digit(b) || is_paren(b)) ? IDN_DEAD : IDN_RUN;
			IDN_RUN: if (is_space(b) || is_paren(b)) n.idn = IDN_DEAD;
			default: n.idn = s.idn;
		endcase
		unique case (s.kwd)
			KWD_EMPTY: n.kwd = (b == "f") ? KWD_F : KWD_OTHER;
			KWD_F: n.kwd = (b == "n") ? KWD_FN : KWD_OTHER;
			default: n.kwd = KWD_OTHER;
		endcase
		return n;
	endfunction

	function automatic logic scan_alive(input scan_t s);
		return s.cmt != CMT_DEAD || s.par != PAR_DEAD || s.dec != DEC_DEAD ||
			s.hex != HEX_DEAD || s.flt != FLT_DEAD || s.str != STR_DEAD ||
			s.chr != CHR_DEAD || s.spc != SPC_DEAD || s.idn != IDN_DEAD;
	endfunction

	function automatic logic [3:0] scan_kind(input scan_t s);
		logic [3:0] k;
		if (s.cmt >= CMT_LINE && s.cmt <= CMT_CLOSED) k = KIND_COMMENT;
		else if (s.par == PAR_LEFT || s.par == PAR_RIGHT)
			k = s.par_left ? KIND_LPAREN : KIND_RPAREN;
		else if (s.dec == DEC_ZERO || s.dec == DEC_DIGITS) k = KIND_INTEGER;
		else if (s.hex == HEX_DIGITS) k = KIND_INTEGER;
		else if (s.flt == FLT_FRAC || s.flt == FLT_SUFFIX) k = KIND_FLOAT;
		else if (s.str == STR_CLOSED) k = KIND_STRING;
		else if (s.chr == CHR_CLOSED) k = KIND_CHAR;
		else if (s.spc == SPC_RUN) k = KIND_SPACE;
		else if (s.idn == IDN_RUN) k = (s.kwd == KWD_FN) ? KIND_KEYWORD : KIND_IDENT;
		else k = KIND_ERROR;
		return k;
	endfunction

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	// lexer state
	logic                   started_q;
	scan_t                  scan_q;
	logic [LENGTH_BITS-1:0] plen_q;
	logic [OFFSET_BITS-1:0] pstart_q;
	logic [OFFSET_BITS-1:0] offset_q;

	// token queue
	token_t                    queue_q [QDEPTH];
	logic [$clog2(QDEPTH)-1:0] rd_ptr_q;
	logic [$clog2(QDEPTH)-1:0] wr_ptr_q;
	logic [$clog2(QDEPTH):0]   count_q;

	logic lex_go;
	logic pop;
	logic in_take;

	assign lex_go = valid_s1 && count_q <= ($clog2(QDEPTH)+1)'(QDEPTH - 2);
	assign in_stall = valid_s1 && !lex_go;
	assign in_take = in_valid && !in_stall;
	assign out_valid = count_q != '0;
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (lex_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
			eoi_s1 <= end_of_input;
		end
	end

	// lexing step
	scan_t                  adv;
	scan_t                  fresh;
	logic                   adv_ok;
	logic                   fresh_ok;
	logic                   e_start;
	logic                   e_pend;
	logic                   e_tail;
	token_t                 t_pend;
	token_t                 t_tail;
	token_t                 slot0;
	token_t                 slot1;
	logic                   push0;
	logic                   push1;
	scan_t                  scan_d;
	logic [LENGTH_BITS-1:0] plen_d;
	logic [OFFSET_BITS-1:0] pstart_d;
	logic [OFFSET_BITS-1:0] offset_d;
	logic [OFFSET_BITS-1:0] offset_inc;

	assign adv = scan_next(scan_q, byte_s1);
	assign fresh = scan_next('0, byte_s1);
	assign adv_ok = scan_alive(adv);
	assign fresh_ok = scan_alive(fresh);
	assign offset_inc = offset_q + OFFSET_BITS'(1);

	always_comb begin
		e_start = !started_q;
		e_pend = 1'b0;
		e_tail = 1'b0;
		t_pend = '{kind: scan_kind(scan_q), start: pstart_q, length: plen_q, last: 1'b0};
		t_tail = '{kind: KIND_EOF, start: offset_q, length: '0, last: 1'b0};
		scan_d = scan_q;
		plen_d = plen_q;
		pstart_d = pstart_q;
		offset_d = offset_q;
		if (eoi_s1) begin
			// flush, then eof
			e_pend = plen_q != '0;
			e_tail = 1'b1;
			scan_d = '0;
			plen_d = '0;
			pstart_d = offset_q;
		end else begin
			offset_d = offset_inc;
			if (adv_ok) begin
				scan_d = adv;
				if (plen_q != '1) plen_d = plen_q + LENGTH_BITS'(1);
			end else begin
				e_pend = plen_q != '0;
				pstart_d = offset_q;
				if (fresh_ok) begin
					scan_d = fresh;
					plen_d = LENGTH_BITS'(1);
				end else begin
					// unusable byte: consume it as a one-byte error
					e_tail = 1'b1;
					t_tail = '{kind: KIND_ERROR, start: offset_q,
						length: LENGTH_BITS'(1), last: 1'b0};
					scan_d = '0;
					plen_d = '0;
					pstart_d = offset_inc;
				end
			end
		end

		// at most two of the three candidates are ever present
		slot0 = e_start ? token_t'{kind: KIND_START, start: '0, length: '0, last: 1'b0}
			: e_pend ? t_pend : t_tail;
		slot1 = (e_start && e_pend) ? t_pend : t_tail;
		push0 = lex_go && (e_start || e_pend || e_tail);
		push1 = lex_go && ((e_start && (e_pend || e_tail)) || (e_pend && e_tail));
		slot0.last = !push1;
		slot1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			scan_q <= '0;
			plen_q <= '0;
			pstart_q <= '0;
			offset_q <= '0;
		end else if (lex_go) begin
			started_q <= 1'b1;
			scan_q <= scan_d;
			plen_q <= plen_d;
			pstart_q <= pstart_d;
			offset_q <= offset_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_q + ($clog2(QDEPTH))'(pop);
			wr_ptr_q <= wr_ptr_q + ($clog2(QDEPTH))'(push0) + ($clog2(QDEPTH))'(push1);
			count_q <= count_q + ($clog2(QDEPTH)+1)'(push0) + ($clog2(QDEPTH)+1)'(push1)
				- ($clog2(QDEPTH)+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			if (push0 && wr_ptr_q == ($clog2(QDEPTH))'(i))
				queue_q[i] <= slot0;
			else if (push1 && wr_ptr_q + ($clog2(QDEPTH))'(1) == ($clog2(QDEPTH))'(i))
				queue_q[i] <= slot1;
		end
	end

	assign token_kind = queue_q[rd_ptr_q].kind;
	assign token_start = queue_q[rd_ptr_q].start;
	assign token_length = queue_q[rd_ptr_q].length;
	assign last_of_run = queue_q[rd_ptr_q].last;

endmodule

`default_nettype wire

/* rtl/mml_checker.sv */
// ----------------------------------------------------------------------------
// mml_checker
// Port-level checks on the token stream of the maximal munch lexer.
// ----------------------------------------------------------------------------
`default_nettype none

module mml_checker #(
	parameter int OFFSET_BITS = 32,
	parameter int LENGTH_BITS = 16
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_stall,
	input wire logic [7:0]             in_byte,
	input wire logic                   end_of_input,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic [3:0]             token_kind,
	input wire logic [OFFSET_BITS-1:0] token_start,
	input wire logic [LENGTH_BITS-1:0] token_length,
	input wire logic                   last_of_run
);
	import mml_pkg::*;

	// hold a stalled request
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(end_of_input))
		else $error("request changed while stalled");

	// hold a stalled token
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind) &&
		$stable(token_start) && $stable(token_length) && $stable(last_of_run))
		else $error("token dropped or changed while stalled");

	// start and eof carry no text
	a_marker_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == KIND_START || token_kind == KIND_EOF)
		|-> token_length == '0)
		else $error("start or eof token with non-zero length");

	// every text token covers at least one byte
	a_text_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != KIND_START && token_kind != KIND_EOF
		|-> token_length != '0)
		else $error("empty text token");

	// eof always closes its request
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_EOF |-> last_of_run)
		else $error("eof token not last of its request");

endmodule

bind maximal_munch_lexer mml_checker #(
	.OFFSET_BITS(OFFSET_BITS),
	.LENGTH_BITS(LENGTH_BITS)
) u_mml_checker (.*);

`default_nettype wire
